/* design/tccc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text cell cursor controller package
// Shared constants, command and result codes, and the result record.
// ----------------------------------------------------------------------------
package tccc_pkg;

    // Number of glyphs in the font, counted from the first code.
    localparam int GLYPH_COUNT = 96;

    // Command codes carried on the request side.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_PUT   = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_DRAW        = 3'd0;
    localparam logic [2:0] KIND_SCROLL_UP   = 3'd1;
    localparam logic [2:0] KIND_SCROLL_DOWN = 3'd2;
    localparam logic [2:0] KIND_CLEAR       = 3'd3;
    localparam logic [2:0] KIND_CURSOR      = 3'd4;
    localparam logic [2:0] KIND_ERROR       = 3'd5;

    // Special character codes.
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_DEL   = 8'h7F;
    localparam logic [7:0] CODE_SPACE = 8'h20;

    // Configuration register indexes.
    localparam logic [2:0] REG_COLUMNS    = 3'd0;
    localparam logic [2:0] REG_ROWS       = 3'd1;
    localparam logic [2:0] REG_LEFT       = 3'd2;
    localparam logic [2:0] REG_TOP        = 3'd3;
    localparam logic [2:0] REG_RIGHT      = 3'd4;
    localparam logic [2:0] REG_BOTTOM     = 3'd5;
    localparam logic [2:0] REG_MODE       = 3'd6;
    localparam logic [2:0] REG_FIRST_CODE = 3'd7;

    // Mode flag bit positions.
    localparam int MODE_AUTO   = 0;
    localparam int MODE_SCROLL = 1;
    localparam int MODE_DOUBLE = 2;

    // One result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic [7:0] glyph_index;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

/* design/text_cell_cursor_controller_unit.sv */
`default_nettype none
// The first result of a request goes to the output register, or to the result queue
// while the output is held. Throughput: one request per cycle while each request yields
// a single result and the output is not held; a request with k results (k up to three)
// queues the rest, and new requests wait while a three-entry result queue holds entries.
// Reset: the cursor returns to the origin, registers take their defaults, and
// all queued results are dropped.
// ----------------------------------------------------------------------------
// Text cell cursor controller
// Decodes console commands, keeps the cursor inside the margin window and
// issues draw, scroll, clear, cursor and error results.
// ----------------------------------------------------------------------------
module text_cell_cursor_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code, pos_col, pos_row
    input  wire logic [1:0]  s_tuser,   // action
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // cell_col, cell_row, glyph_index, cursor_col, cursor_row
    output logic [2:0]       m_tuser,   // kind
    output logic             m_tlast
);

    localparam logic [8:0] GLYPHS = 9'(tccc_pkg::GLYPH_COUNT);

    // Configuration registers
    logic [7:0] columns_reg, rows_reg, left_reg, top_reg, right_reg, bottom_reg;
    logic [2:0] mode_reg;
    logic [7:0] first_reg;

    // Cursor state
    logic [7:0] cur_col_reg, cur_row_reg;
    logic [7:0] cur_col_next, cur_row_next;

    // Result queue and output register
    tccc_pkg::result_t pend_reg [3];
    logic [1:0]        pend_cnt_reg;
    tccc_pkg::result_t out_reg;
    logic              out_valid_reg;

    // Decode and window signals
    logic [1:0]  action;
    logic [7:0]  code, pos_col, pos_row;
    logic [7:0]  c0, c1, r0, r1;
    logic [9:0]  c1_wide, r1_wide;
    logic [7:0]  col, row;
    logic        scroll_mode, double_mode, auto_mode;
    logic        space_ok, code_ok, put_ok, pos_in;
    logic [7:0]  put_glyph;
    logic        v_up, use_v, scrolls_first;
    logic [8:0]  v1, v2;
    logic [7:0]  v_line;
    logic [1:0]  v_nsc, nsc;
    logic [7:0]  scroll_col;
    logic [2:0]  scroll_kind;
    tccc_pkg::result_t main_res, scroll_res;
    tccc_pkg::result_t res [3];
    logic [1:0]  res_cnt;
    logic        accept, out_free;

    // Test a character code against the font range.
    function automatic logic glyph_ok(input logic [7:0] c, input logic [7:0] first);
        logic [7:0] diff;
        diff = c - first;
        return (c >= first) && ({1'b0, diff} < GLYPHS);
    endfunction

    // One vertical step: returns {scrolled, new line}.
    function automatic logic [8:0] vstep(input logic [7:0] line, input logic up,
                                         input logic [7:0] top, input logic [7:0] bot,
                                         input logic scr);
        logic [8:0] r;
        if (up) begin
            if (line == top) begin
                r = scr ? {1'b1, line} : {1'b0, bot};
            end else begin
                r = {1'b0, line - 8'd1};
            end
        end else begin
            if (line == bot) begin
                r = scr ? {1'b1, line} : {1'b0, top};
            end else begin
                r = {1'b0, line + 8'd1};
            end
        end
        return r;
    endfunction

    assign action  = s_tuser;
    assign code    = s_tdata[7:0];
    assign pos_col = s_tdata[15:8];
    assign pos_row = s_tdata[23:16];

    assign scroll_mode = mode_reg[tccc_pkg::MODE_SCROLL];
    assign double_mode = mode_reg[tccc_pkg::MODE_DOUBLE];
    assign auto_mode   = mode_reg[tccc_pkg::MODE_AUTO];

    // Window bounds; an empty window collapses onto the leading margin.
    always_comb
    begin
        c0 = left_reg;
        r0 = top_reg;
        c1_wide = {2'b00, columns_reg} - {2'b00, right_reg} - 10'd1;
        r1_wide = {2'b00, rows_reg} - {2'b00, bottom_reg} - 10'd1;
        c1 = ($signed(c1_wide) < $signed({2'b00, c0})) ? c0 : c1_wide[7:0];
        r1 = ($signed(r1_wide) < $signed({2'b00, r0})) ? r0 : r1_wide[7:0];
    end

    // Cursor clamped into the window.
    always_comb
    begin
        col = cur_col_reg;
        if (col < c0) col = c0;
        if (col > c1) col = c1;
        row = cur_row_reg;
        if (row < r0) row = r0;
        if (row > r1) row = r1;
    end

    assign space_ok  = glyph_ok(tccc_pkg::CODE_SPACE, first_reg);
    assign code_ok   = glyph_ok(code, first_reg);
    assign pos_in    = (pos_col >= c0) && (pos_col <= c1) && (pos_row >= r0) && (pos_row <= r1);
    assign put_glyph = ((code == tccc_pkg::CODE_BS) || (code == tccc_pkg::CODE_DEL))
                     ? tccc_pkg::CODE_SPACE : code;
    assign put_ok    = glyph_ok(put_glyph, first_reg);

    // Shared vertical stepper, one or two steps.
    assign v_up   = (code == tccc_pkg::CODE_BS);
    assign v1     = vstep(row, v_up, r0, r1, scroll_mode);
    assign v2     = vstep(v1[7:0], v_up, r0, r1, scroll_mode);
    assign v_line = double_mode ? v2[7:0] : v1[7:0];
    assign v_nsc  = {1'b0, v1[8]} + {1'b0, double_mode & v2[8]};

    // Command decode: a main result plus zero to two scroll results.
    always_comb
    begin
        main_res      = '0;
        use_v         = 1'b0;
        scrolls_first = 1'b1;
        scroll_col    = col;
        cur_col_next  = col;
        cur_row_next  = row;
        main_res.kind       = tccc_pkg::KIND_ERROR;
        case (action)
            tccc_pkg::ACT_WRITE:
            begin
                if (code == tccc_pkg::CODE_CR) begin
                    use_v        = 1'b1;
                    scroll_col   = col;
                    cur_col_next = c0;
                    cur_row_next = v_line;
                    main_res.kind = tccc_pkg::KIND_CURSOR;
                end else if ((code == tccc_pkg::CODE_BS) || (code == tccc_pkg::CODE_DEL)) begin
                    if (space_ok) begin
                        main_res.kind        = tccc_pkg::KIND_DRAW;
                        main_res.glyph_index = tccc_pkg::CODE_SPACE - first_reg;
                        if (code == tccc_pkg::CODE_BS) begin
                            if (col == c0) begin
                                use_v        = 1'b1;
                                scroll_col   = c1;
                                cur_col_next = c1;
                                cur_row_next = v_line;
                            end else begin
                                cur_col_next = col - 8'd1;
                            end
                        end
                        main_res.cell_col = cur_col_next;
                        main_res.cell_row = cur_row_next;
                    end
                end else if (code_ok) begin
                    main_res.kind        = tccc_pkg::KIND_DRAW;
                    main_res.glyph_index = code - first_reg;
                    main_res.cell_col    = col;
                    main_res.cell_row    = row;
                    scrolls_first        = 1'b0;
                    if (auto_mode) begin
                        if (col == c1) begin
                            use_v        = 1'b1;
                            scroll_col   = c0;
                            cur_col_next = c0;
                            cur_row_next = v_line;
                        end else begin
                            cur_col_next = col + 8'd1;
                        end
                    end
                end
            end
            tccc_pkg::ACT_PUT:
            begin
                if (pos_in) begin
                    if (code == tccc_pkg::CODE_CR) begin
                        main_res.kind = tccc_pkg::KIND_CURSOR;
                    end else if (put_ok) begin
                        main_res.kind        = tccc_pkg::KIND_DRAW;
                        main_res.cell_col    = pos_col;
                        main_res.cell_row    = pos_row;
                        main_res.glyph_index = put_glyph - first_reg;
                    end
                end
            end
            tccc_pkg::ACT_SET:
            begin
                if (pos_in) begin
                    cur_col_next  = pos_col;
                    cur_row_next  = pos_row;
                    main_res.kind = tccc_pkg::KIND_CURSOR;
                end
            end
            default:
            begin
                cur_col_next  = c0;
                cur_row_next  = r0;
                main_res.kind = tccc_pkg::KIND_CLEAR;
            end
        endcase
        main_res.cursor_col = cur_col_next;
        main_res.cursor_row = cur_row_next;
    end

    // Scroll record, identical for every scroll of one request.
    always_comb
    begin
        nsc         = use_v ? v_nsc : 2'd0;
        scroll_kind = v_up ? tccc_pkg::KIND_SCROLL_DOWN : tccc_pkg::KIND_SCROLL_UP;
        scroll_res            = '0;
        scroll_res.kind       = scroll_kind;
        scroll_res.cursor_col = scroll_col;
        scroll_res.cursor_row = cur_row_next;
    end

    // Order the results and mark the final one.
    always_comb
    begin
        res_cnt = nsc + 2'd1;
        for (int i = 0; i < 3; i++) begin
            if (scrolls_first) begin
                res[i] = (2'(i) < nsc) ? scroll_res : main_res;
            end else begin
                res[i] = (i == 0) ? main_res : scroll_res;
            end
            res[i].last = (2'(i) == nsc);
        end
    end

    // Handshake control
    assign s_tready = (pend_cnt_reg == 2'd0);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            columns_reg <= 8'd40;
            rows_reg    <= 8'd30;
            left_reg    <= 8'd0;
            top_reg     <= 8'd0;
            right_reg   <= 8'd0;
            bottom_reg  <= 8'd0;
            mode_reg    <= 3'd3;
            first_reg   <= 8'd32;
        end else if (cfg_wen) begin
            case (cfg_index)
                tccc_pkg::REG_COLUMNS:    columns_reg <= cfg_data;
                tccc_pkg::REG_ROWS:       rows_reg    <= cfg_data;
                tccc_pkg::REG_LEFT:       left_reg    <= cfg_data;
                tccc_pkg::REG_TOP:        top_reg     <= cfg_data;
                tccc_pkg::REG_RIGHT:      right_reg   <= cfg_data;
                tccc_pkg::REG_BOTTOM:     bottom_reg  <= cfg_data;
                tccc_pkg::REG_MODE:       mode_reg    <= cfg_data[2:0];
                tccc_pkg::REG_FIRST_CODE: first_reg   <= cfg_data;
                default:                  mode_reg    <= mode_reg;
            endcase
        end
    end

    // Cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_col_reg <= 8'd0;
            cur_row_reg <= 8'd0;
        end else if (accept) begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    // Queue count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (pend_cnt_reg != 2'd0) begin
                pend_cnt_reg  <= pend_cnt_reg - 2'd1;
                out_valid_reg <= 1'b1;
            end else if (accept) begin
                pend_cnt_reg  <= res_cnt - 2'd1;
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            pend_cnt_reg <= res_cnt;
        end
    end

    // Queue and output payload
    always_ff @(posedge clk)
    begin
        if (out_free) begin
            if (pend_cnt_reg != 2'd0) begin
                out_reg     <= pend_reg[0];
                pend_reg[0] <= pend_reg[1];
                pend_reg[1] <= pend_reg[2];
            end else if (accept) begin
                out_reg     <= res[0];
                pend_reg[0] <= res[1];
                pend_reg[1] <= res[2];
            end
        end else if (accept) begin
            pend_reg[0] <= res[0];
            pend_reg[1] <= res[1];
            pend_reg[2] <= res[2];
        end
    end

    // Result stream ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.cursor_row, out_reg.cursor_col, out_reg.glyph_index,
                       out_reg.cell_row, out_reg.cell_col};

endmodule
`default_nettype wire
